// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL of the texel modulation select block.
// No dependencies; SYNTH removes every check from the netlist.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset
`define TMS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("tms assertion failed");
// Condition must never be seen outside reset
`define TMS_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("tms forbidden condition seen");
`else
`define TMS_ASSERT(label, clk, rst, prop)
`define TMS_NEVER(label, clk, rst, cond)
`endif
`endif

// ----- rtl/core/tms_pkg.sv -----
// Types, widths and constants for the texel modulation select block.
// No dependencies; used by tms_min_tree and texel_modulation_select.
package tms_pkg;

   localparam int CAND_COUNT  = 8;   // candidate weights evaluated per texel
   localparam int MODE0_COUNT = 4;
   localparam int CHAN_COUNT  = 3;
   localparam int DIFF_W      = 12;  // |diff| <= 2040
   localparam int SQ_W        = 22;  // diff^2 <= 4161600
   localparam int ERR_W       = 24;
   localparam int IDX_W       = 3;
   localparam int ADDR_W      = 3;

   // Register map (word index = paddr[2])
   localparam logic REG_LUMA_MODE = 1'b0;

   localparam logic [3:0] SCALE_MODE0 = 4'd8;
   localparam logic [3:0] SCALE_MODE1 = 4'd7;

   // Larger than any real error, so unused candidates never win
   localparam logic [ERR_W-1:0] ERR_NONE = '1;

   typedef logic signed [DIFF_W-1:0] diff_type;
   typedef logic [SQ_W-1:0]          sq_type;
   typedef logic [ERR_W-1:0]         err_type;
   typedef logic [IDX_W-1:0]         idx_type;

   // Control that travels with each beat
   typedef struct packed {
      logic valid;
      logic last;
   } beat_ctl_type;

   // Weight numerator for candidate k: mode 0 uses {0,3,5,8}/8, mode 1 uses k/7
   function automatic logic [3:0] cand_num(input logic mode, input idx_type k);
      logic [3:0] num;
      if (mode) begin
         num = {1'b0, k};
      end else begin
         unique case (k[1:0])
            2'd0: num = 4'd0;
            2'd1: num = 4'd3;
            2'd2: num = 4'd5;
            2'd3: num = 4'd8;
            default: num = 4'd0;
         endcase
      end
      return num;
   endfunction

endpackage

// ----- rtl/core/tms_min_tree.sv -----
// Two-stage registered minimum search over the eight candidate errors.
// Depends on tms_pkg; the second stage is the block's output register.
module tms_min_tree (
   input  logic                  clock,
   input  logic                  reset,
   input  tms_pkg::beat_ctl_type in_ctl,
   input  tms_pkg::err_type      in_err [tms_pkg::CAND_COUNT],
   output logic                  in_ready,
   output logic                  out_valid,
   input  logic                  out_ready,
   output tms_pkg::idx_type      out_idx,
   output tms_pkg::err_type      out_err,
   output logic                  out_last
);

   localparam int HALF = tms_pkg::CAND_COUNT / 2;

   // Stage A: pairwise minimum, 8 -> 4
   tms_pkg::beat_ctl_type a_ctl_ff;
   tms_pkg::err_type      a_err_ff [HALF];
   tms_pkg::err_type      a_err_in [HALF];
   tms_pkg::idx_type      a_idx_ff [HALF];
   tms_pkg::idx_type      a_idx_in [HALF];
   logic                  a_ready;

   // Stage B: final minimum, 4 -> 1
   logic                  b_valid_ff;
   logic                  b_last_ff;
   tms_pkg::err_type      b_err_ff;
   tms_pkg::idx_type      b_idx_ff;
   tms_pkg::err_type      b_err_in;
   tms_pkg::idx_type      b_idx_in;
   tms_pkg::err_type      lo_err;
   tms_pkg::err_type      hi_err;
   tms_pkg::idx_type      lo_idx;
   tms_pkg::idx_type      hi_idx;
   logic                  b_ready;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_ctl_ff.valid || b_ready;
   assign in_ready = a_ready;

   // Lower index wins ties: take the upper one only when strictly smaller
   always_comb begin
      for (int p = 0; p < HALF; p++) begin
         if (in_err[2*p+1] < in_err[2*p]) begin
            a_err_in[p] = in_err[2*p+1];
            a_idx_in[p] = tms_pkg::IDX_W'(2*p+1);
         end else begin
            a_err_in[p] = in_err[2*p];
            a_idx_in[p] = tms_pkg::IDX_W'(2*p);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff <= '0;
      end else if (a_ready) begin
         a_ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_ctl.valid) begin
         a_err_ff <= a_err_in;
         a_idx_ff <= a_idx_in;
      end
   end

   // Two compare levels on the four survivors
   always_comb begin
      if (a_err_ff[1] < a_err_ff[0]) begin
         lo_err = a_err_ff[1];
         lo_idx = a_idx_ff[1];
      end else begin
         lo_err = a_err_ff[0];
         lo_idx = a_idx_ff[0];
      end
      if (a_err_ff[3] < a_err_ff[2]) begin
         hi_err = a_err_ff[3];
         hi_idx = a_idx_ff[3];
      end else begin
         hi_err = a_err_ff[2];
         hi_idx = a_idx_ff[2];
      end
      if (hi_err < lo_err) begin
         b_err_in = hi_err;
         b_idx_in = hi_idx;
      end else begin
         b_err_in = lo_err;
         b_idx_in = lo_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_ctl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready && a_ctl_ff.valid) begin
         b_err_ff  <= b_err_in;
         b_idx_ff  <= b_idx_in;
         b_last_ff <= a_ctl_ff.last;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_idx   = b_idx_ff;
   assign out_err   = b_err_ff;
   assign out_last  = b_last_ff;

endmodule

// ----- rtl/core/texel_modulation_select.sv -----
// Top level of the texel modulation select block: error pipeline and CSR port.
// Depends on tms_pkg, tms_min_tree and assert_macros.svh.
//
// Usage:
//  - Input channel (req_*): one beat per texel with original, dark and bright
//    colors (three 8-bit channels, channel 0 in bits 23:16) and a last mark.
//  - Result channel (rsp_*): one beat per texel with the chosen weight index,
//    its scaled squared error (x64 in mode 0, x49 in mode 1) and the last mark.
//  - CSR port (APB-style, pready tied high): word 0 bit 0 is luma_mode,
//    0 = four weights on three channels, 1 = eight weights on channel 0.
//    Write it only while no texel is in flight.
//  - Pipeline: a result passes through five register stages (diff, square,
//    sum, pairwise min, final min) after its input beat is accepted.
//  - Throughput: one texel per cycle while the receiver does not stall; all
//    eight candidates are evaluated in parallel.
//  - Reset clears all stage valid bits and luma_mode; no result is pending.
//  - When the receiver stalls, the result is held in the output register and
//    earlier stages keep filling until every one of the five stages is full;
//    only then does req_ready drop.
`include "assert_macros.svh"

module texel_modulation_select (
   input  logic                          clock,
   input  logic                          reset,
   // input channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [23:0]                   req_orig_color,
   input  logic [23:0]                   req_dark_color,
   input  logic [23:0]                   req_bright_color,
   input  logic                          req_last_texel,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tms_pkg::IDX_W-1:0]     rsp_weight_index,
   output logic [tms_pkg::ERR_W-1:0]     rsp_best_error,
   output logic                          rsp_last_out,
   // configuration port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tms_pkg::ADDR_W-1:0]    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   localparam int NK = tms_pkg::CAND_COUNT;
   localparam int NC = tms_pkg::CHAN_COUNT;

   // ---------------------------------------------------------------
   // Configuration register
   // ---------------------------------------------------------------
   logic luma_mode_ff;
   logic csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == tms_pkg::REG_LUMA_MODE);

   always_ff @(posedge clock) begin
      if (reset) begin
         luma_mode_ff <= 1'b0;
      end else if (csr_write) begin
         luma_mode_ff <= pwdata[0];
      end
   end

   assign prdata = (paddr[2] == tms_pkg::REG_LUMA_MODE) ? {31'b0, luma_mode_ff} : 32'b0;

   // ---------------------------------------------------------------
   // Stage control: each stage loads when empty or when the next loads
   // ---------------------------------------------------------------
   tms_pkg::beat_ctl_type s1_ctl_ff, s2_ctl_ff, s3_ctl_ff;
   logic s1_mode_ff, s2_mode_ff, s3_mode_ff;
   logic s1_ready, s2_ready, s3_ready, tree_ready;
   tms_pkg::beat_ctl_type req_ctl;

   assign s3_ready  = !s3_ctl_ff.valid || tree_ready;
   assign s2_ready  = !s2_ctl_ff.valid || s3_ready;
   assign s1_ready  = !s1_ctl_ff.valid || s2_ready;
   assign req_ready = s1_ready;

   assign req_ctl.valid = req_valid;
   assign req_ctl.last  = req_last_texel;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         s3_ctl_ff <= '0;
      end else begin
         if (s1_ready) s1_ctl_ff <= req_ctl;
         if (s2_ready) s2_ctl_ff <= s1_ctl_ff;
         if (s3_ready) s3_ctl_ff <= s2_ctl_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: signed scaled difference per candidate and channel
   //   diff = s*(d - o) + n*(b - d)
   // ---------------------------------------------------------------
   tms_pkg::diff_type s1_diff_ff [NK][NC];
   tms_pkg::diff_type s1_diff_in [NK][NC];

   always_comb begin
      logic [3:0]         scale;
      logic [3:0]         num;
      logic signed [12:0] d_m_o;
      logic signed [12:0] b_m_d;
      logic signed [12:0] acc;
      scale = luma_mode_ff ? tms_pkg::SCALE_MODE1 : tms_pkg::SCALE_MODE0;
      for (int k = 0; k < NK; k++) begin
         num = tms_pkg::cand_num(luma_mode_ff, tms_pkg::IDX_W'(k));
         for (int c = 0; c < NC; c++) begin
            d_m_o = $signed({5'b0, req_dark_color[23-8*c -: 8]})
                  - $signed({5'b0, req_orig_color[23-8*c -: 8]});
            b_m_d = $signed({5'b0, req_bright_color[23-8*c -: 8]})
                  - $signed({5'b0, req_dark_color[23-8*c -: 8]});
            acc   = $signed({9'b0, scale}) * d_m_o + $signed({9'b0, num}) * b_m_d;
            s1_diff_in[k][c] = acc[tms_pkg::DIFF_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_valid) begin
         s1_diff_ff <= s1_diff_in;
         s1_mode_ff <= luma_mode_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: squares
   // ---------------------------------------------------------------
   tms_pkg::sq_type s2_sq_ff [NK][NC];
   tms_pkg::sq_type s2_sq_in [NK][NC];

   always_comb begin
      logic signed [23:0] prod;
      for (int k = 0; k < NK; k++) begin
         for (int c = 0; c < NC; c++) begin
            prod = s1_diff_ff[k][c] * s1_diff_ff[k][c];
            s2_sq_in[k][c] = prod[tms_pkg::SQ_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_ctl_ff.valid) begin
         s2_sq_ff   <= s2_sq_in;
         s2_mode_ff <= s1_mode_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: channel sums (mode 1: channel 0); unused mode-0 slots never win
   // ---------------------------------------------------------------
   tms_pkg::err_type s3_err_ff [NK];
   tms_pkg::err_type s3_err_in [NK];

   always_comb begin
      for (int k = 0; k < NK; k++) begin
         if (s2_mode_ff) begin
            s3_err_in[k] = tms_pkg::ERR_W'(s2_sq_ff[k][0]);
         end else if (k >= tms_pkg::MODE0_COUNT) begin
            s3_err_in[k] = tms_pkg::ERR_NONE;
         end else begin
            s3_err_in[k] = tms_pkg::ERR_W'(s2_sq_ff[k][0])
                         + tms_pkg::ERR_W'(s2_sq_ff[k][1])
                         + tms_pkg::ERR_W'(s2_sq_ff[k][2]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && s2_ctl_ff.valid) begin
         s3_err_ff  <= s3_err_in;
         s3_mode_ff <= s2_mode_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stages 4-5: minimum search and output register
   // ---------------------------------------------------------------
   tms_min_tree u_min_tree (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (s3_ctl_ff),
      .in_err    (s3_err_ff),
      .in_ready  (tree_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_idx   (rsp_weight_index),
      .out_err   (rsp_best_error),
      .out_last  (rsp_last_out)
   );

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   // Input back-pressure only when every stage holds a beat
   `TMS_ASSERT(a_full_before_stall, clock, reset,
      !req_ready |-> (s1_ctl_ff.valid && s2_ctl_ff.valid && s3_ctl_ff.valid && !tree_ready))
   // Mode 0 never selects one of the upper four weights
   `TMS_ASSERT(a_mode0_index_range, clock, reset,
      (rsp_valid && !luma_mode_ff) |-> (rsp_weight_index[2] == 1'b0))
   // Unused mode-0 candidates are parked at the sentinel error
   `TMS_ASSERT(a_mode0_unused_err, clock, reset,
      (s3_ctl_ff.valid && !s3_mode_ff) |->
         (s3_err_ff[4] == tms_pkg::ERR_NONE && s3_err_ff[7] == tms_pkg::ERR_NONE))
   // A real error never reaches the sentinel value
   `TMS_NEVER(a_err_not_sentinel, clock, reset,
      rsp_valid && (rsp_best_error == tms_pkg::ERR_NONE))

endmodule
